// ===== hw/rtl/cfbq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfbq_pkg: shared types for the circular find-first-set bucket queue
// Transaction payloads, command codes and controller-to-datapath commands.
// ----------------------------------------------------------------------------
package cfbq_pkg;

  // Fixed field widths of the transaction payloads
  localparam int ACT_W  = 2;
  localparam int PRIO_W = 32;
  localparam int BKT_W  = 10;
  localparam int KEY_W  = 11;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Command codes; the remaining code is a no-op
  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ    = 2'd0,
    ACT_PEEK   = 2'd1,
    ACT_REMOVE = 2'd2
  } cfbq_action_e;

  // Input transaction
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [PRIO_W-1:0] prio;
    logic [BKT_W-1:0]  bucket;
  } cfbq_item_t;

  // Result transaction
  typedef struct packed {
    logic              status;
    logic [BKT_W-1:0]  bucket_out;
    logic [KEY_W-1:0]  buffer_key;
    logic              primary_half;
    logic [PRIO_W-1:0] base_prio;
  } cfbq_result_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } cfbq_state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;  // latch the transaction and issue the leaf read
    logic exec;     // leaf data is back: update state, register the result
  } cfbq_cmd_t;

endpackage

// ===== hw/rtl/cfbq_ram.sv =====
// ----------------------------------------------------------------------------
// cfbq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module cfbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cfbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfbq_ctrl: transaction sequencer
// Accepts a command, runs the leaf read-modify-write cycle, strobes the result.
// ----------------------------------------------------------------------------
module cfbq_ctrl
  import cfbq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      result_valid_o,
  output cfbq_cmd_t cmd_o
);

  cfbq_state_e state_q, state_d;
  logic        valid_q;

  // State register and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= cmd_o.exec;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy           = (state_q == ST_EXEC);
  assign result_valid_o = valid_q;

`ifndef SYNTH
  // An accepted transaction always occupies the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // The execute cycle is followed by the result strobe and a free slot
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && result_valid_o))
    else $error("execute cycle not followed by result strobe");

  // Capture is never issued while a transaction is in flight
  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (!busy && !result_valid_o || !busy))
    else $error("capture issued while busy");
`endif

endmodule

// ===== hw/rtl/cfbq_dpath.sv =====
// ----------------------------------------------------------------------------
// cfbq_dpath: bitmap datapath of the bucket queue
// Top words, primary select and base in flops; leaf words in a RAM with
// per-entry valid bits so that reset reads back as zero.
// ----------------------------------------------------------------------------
module cfbq_dpath
  import cfbq_pkg::*;
#(
  parameter int WORD_SHIFT = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfbq_cmd_t    cmd_i,
  input  cfbq_item_t   item_i,
  output cfbq_result_t result_o
);

  localparam int WORD_BITS    = 1 << WORD_SHIFT;
  localparam int OFF_W        = 2 * WORD_SHIFT;
  localparam int REL_W        = OFF_W + 1;
  localparam int LEAF_DEPTH   = 2 * WORD_BITS;
  localparam int LEAF_AW      = WORD_SHIFT + 1;
  localparam int HALF_BUCKETS = 1 << OFF_W;

  // Lowest set bit of a word, zero for an empty word
  function automatic logic [WORD_SHIFT-1:0] ffs(input logic [WORD_BITS-1:0] w);
    logic [WORD_SHIFT-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) r = WORD_SHIFT'(i);
    end
    return r;
  endfunction

  // Architectural state
  logic [WORD_BITS-1:0]  top_q [2];
  logic [WORD_BITS-1:0]  top_d [2];
  logic                  sel_q, sel_d;
  logic [PRIO_W-1:0]     base_q, base_d;
  logic [LEAF_DEPTH-1:0] vld_q;

  // Transaction registers
  logic [ACT_W-1:0]      act_q;
  logic                  half_q;
  logic [WORD_SHIFT-1:0] hi_q, lo_q;
  logic                  swap_q, empty_q, lvld_q;
  cfbq_result_t          result_q, result_d;

  // Capture-cycle address decode
  logic [PRIO_W:0]          diff;
  logic [PRIO_W-1:0]        rel;
  logic [REL_W-1:0]         rel_c;
  logic                     enq_half;
  logic [OFF_W-1:0]         enq_off;
  logic [OFF_W+BKT_W-1:0]   bkt_wide;
  logic [OFF_W-1:0]         bkt_off;
  logic                     pk_empty, pk_swap, pk_half;
  logic [WORD_SHIFT-1:0]    pk_hi;
  logic                     a_half;
  logic [WORD_SHIFT-1:0]    a_hi, a_lo;
  logic [LEAF_AW-1:0]       raddr;

  // Execute-cycle signals
  logic [WORD_BITS-1:0]     rdata, leaf, lo_bit, hi_bit, wdata;
  logic                     ram_we;
  logic [LEAF_AW-1:0]       waddr;
  logic [WORD_SHIFT-1:0]    lo_out;
  logic                     status, zero_out;
  logic [OFF_W-1:0]         bkt_full;
  logic [OFF_W+BKT_W-1:0]   bkt_out_wide;
  logic [OFF_W+KEY_W:0]     key_wide;

  // Enqueue: relative priority, clamped below zero and at two halves
  assign diff     = {1'b0, item_i.prio} - {1'b0, base_q};
  assign rel      = diff[PRIO_W] ? '0 : diff[PRIO_W-1:0];
  assign rel_c    = (|rel[PRIO_W-1:REL_W]) ? '1 : rel[REL_W-1:0];
  assign enq_half = sel_q ^ rel_c[REL_W-1];
  assign enq_off  = rel_c[OFF_W-1:0];

  // Remove: bucket offset fitted to the half size
  assign bkt_wide = (OFF_W + BKT_W)'(item_i.bucket);
  assign bkt_off  = bkt_wide[OFF_W-1:0];

  // Peek: swap decision and front top bit
  assign pk_empty = (top_q[0] == '0) && (top_q[1] == '0);
  assign pk_swap  = (top_q[sel_q] == '0);
  assign pk_half  = sel_q ^ pk_swap;
  assign pk_hi    = ffs(top_q[pk_half]);

  // Leaf address per command
  always_comb begin
    a_half = 1'b0;
    a_hi   = '0;
    a_lo   = '0;
    case (item_i.action)
      ACT_ENQ: begin
        a_half = enq_half;
        a_hi   = enq_off[OFF_W-1:WORD_SHIFT];
        a_lo   = enq_off[WORD_SHIFT-1:0];
      end
      ACT_PEEK: begin
        a_half = pk_half;
        a_hi   = pk_hi;
      end
      ACT_REMOVE: begin
        a_half = sel_q;
        a_hi   = bkt_off[OFF_W-1:WORD_SHIFT];
        a_lo   = bkt_off[WORD_SHIFT-1:0];
      end
      default: ;
    endcase
  end

  assign raddr = {a_half, a_hi};
  assign waddr = {half_q, hi_q};

  // Leaf word storage
  cfbq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (LEAF_DEPTH)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Execute: read-modify-write of the leaf, top and swap update
  assign leaf   = lvld_q ? rdata : '0;
  assign lo_bit = WORD_BITS'(1) << lo_q;
  assign hi_bit = WORD_BITS'(1) << hi_q;

  always_comb begin
    top_d    = top_q;
    sel_d    = sel_q;
    base_d   = base_q;
    ram_we   = 1'b0;
    wdata    = leaf;
    lo_out   = lo_q;
    status   = STATUS_OK;
    zero_out = 1'b0;
    if (cmd_i.exec) begin
      case (act_q)
        ACT_ENQ: begin
          ram_we        = 1'b1;
          wdata         = leaf | lo_bit;
          top_d[half_q] = top_q[half_q] | hi_bit;
        end
        ACT_PEEK: begin
          if (empty_q) begin
            status   = STATUS_EMPTY;
            zero_out = 1'b1;
          end else begin
            lo_out = ffs(leaf);
            if (swap_q) begin
              sel_d  = ~sel_q;
              base_d = base_q + PRIO_W'(HALF_BUCKETS);
            end
          end
        end
        ACT_REMOVE: begin
          ram_we = 1'b1;
          wdata  = leaf & ~lo_bit;
          if (wdata == '0) begin
            top_d[half_q] = top_q[half_q] & ~hi_bit;
          end
          if ((top_d[half_q] == '0) && (top_q[~half_q] != '0)) begin
            sel_d  = ~sel_q;
            base_d = base_q + PRIO_W'(HALF_BUCKETS);
          end
        end
        default: ;
      endcase
    end
  end

  // Result assembly
  assign bkt_full     = zero_out ? '0 : {hi_q, lo_out};
  assign bkt_out_wide = (OFF_W + BKT_W)'(bkt_full);
  assign key_wide     = zero_out ? '0 : (OFF_W + KEY_W + 1)'({half_q, bkt_full});

  always_comb begin
    result_d.status       = status;
    result_d.bucket_out   = bkt_out_wide[BKT_W-1:0];
    result_d.buffer_key   = key_wide[KEY_W-1:0];
    result_d.primary_half = sel_d;
    result_d.base_prio    = base_d;
  end

  // Control state: bitmaps, select, base, leaf valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q[0] <= '0;
      top_q[1] <= '0;
      sel_q    <= 1'b0;
      base_q   <= '0;
      vld_q    <= '0;
    end else begin
      top_q[0] <= top_d[0];
      top_q[1] <= top_d[1];
      sel_q    <= sel_d;
      base_q   <= base_d;
      if (ram_we) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  // Transaction and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= item_i.action;
      half_q  <= a_half;
      hi_q    <= a_hi;
      lo_q    <= a_lo;
      swap_q  <= pk_swap;
      empty_q <= pk_empty;
      lvld_q  <= vld_q[raddr];
    end
    if (cmd_i.exec) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

`ifndef SYNTH
  // A half swap always comes with a step of the base by the bucket count of one half
  a_swap_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_d != sel_q) |-> (base_d == base_q + PRIO_W'(HALF_BUCKETS)))
    else $error("half swap without base advance");

  // Leaf writes only in the execute cycle, never against a capture read
  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cmd_i.exec && !cmd_i.capture))
    else $error("leaf write outside execute cycle");

  // An enqueue leaves the summary bit of its leaf word set
  a_enq_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (act_q == ACT_ENQ)) |-> top_d[half_q][hi_q])
    else $error("enqueue did not set top bit");
`endif

endmodule

// ===== hw/rtl/circular_ffs_bucket_queue.sv =====
// ----------------------------------------------------------------------------
// circular_ffs_bucket_queue: circular find-first-set bucket priority index
// Two two-level bitmaps (primary and secondary half) with a base priority;
// enqueue marks a bucket, peek finds the front bucket, remove clears one.
// ----------------------------------------------------------------------------
// Each transaction runs as a read step and a modify step: start is taken while busy is low, the
// leaf word is read from RAM in that cycle, and in the following cycle (busy
// high) the leaf word is modified and written back and the top words, half
// select and base are updated. The leaf RAM's registered read is why the
// modify waits for the busy cycle. The result appears on result_o with
// result_valid_o high for one cycle right after the busy cycle, and a new
// transaction may be started in that same cycle. There is no back pressure
// on results: sample them when the strobe is high. Leaf words read as zero
// after reset through per-word valid bits, so the block needs no clearing.
module circular_ffs_bucket_queue
  import cfbq_pkg::*;
#(
  parameter int WORD_SHIFT = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  cfbq_item_t   item_i,
  output logic         busy,
  output logic         result_valid_o,
  output cfbq_result_t result_o
);

  cfbq_cmd_t cmd;

  // Sequencer
  cfbq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  // Bitmap datapath
  cfbq_dpath #(
    .WORD_SHIFT (WORD_SHIFT)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .result_o (result_o)
  );

endmodule
